// ===== hw/rtl/binary_min_heap_queue_core_assert.svh =====
// Assertion macros for the binary min-heap queue core.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define BMHQ_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BMHQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bmhq_pkg.sv =====
// Shared types, constants and index helpers for the binary min-heap queue.
// No dependencies; imported by the compare unit, the top level and the bench.
package bmhq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int KEY_W      = 32;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        FN_INSERT   = 2'd0,
        FN_EXTRACT  = 2'd1,
        FN_DECREASE = 2'd2,
        FN_DELETE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        t_func                    func;
        logic signed [KEY_W-1:0]  key_value;
        logic [HEAP_AW-1:0]       entry_index;
    } t_req;

    typedef struct packed {
        logic signed [KEY_W-1:0]  popped_key;
        t_status                  status;
        logic signed [KEY_W-1:0]  min_key;
        logic [CNT_W-1:0]         entry_count;
    } t_rsp;

    // One level of sift decision, from the compare unit to the sequencer
    typedef struct packed {
        logic                     up_stop;
        logic [HEAP_AW-1:0]       up_parent;
        logic                     down_stop;
        logic [HEAP_AW-1:0]       down_best;
        logic signed [KEY_W-1:0]  down_key;
    } t_sift_dec;

    // Parent of a heap position (meaningless at the root)
    function automatic logic [HEAP_AW-1:0] f_parent(input logic [HEAP_AW-1:0] pos);
        f_parent = HEAP_AW'((pos - 1'b1) >> 1);
    endfunction

    // Left child, 2*pos+1, wide enough to compare against the count
    function automatic logic [HEAP_AW+1:0] f_left(input logic [HEAP_AW-1:0] pos);
        f_left = {1'b0, pos, 1'b1};
    endfunction

    // Right child, 2*pos+2
    function automatic logic [HEAP_AW+1:0] f_right(input logic [HEAP_AW-1:0] pos);
        f_right = {({1'b0, pos} + 1'b1), 1'b0};
    endfunction

endpackage

// ===== hw/rtl/bmhq_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Read during write to the same address returns the old data. No dependencies.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hw/rtl/bmhq_sift_step.sv =====
// Compare unit for one sift level: sift-up stop test and smallest-of-three pick.
// Depends on bmhq_pkg for widths, index helpers and the decision struct.
module bmhq_sift_step
    import bmhq_pkg::*;
(
    input  logic [HEAP_AW-1:0]       i_pos,
    input  logic signed [KEY_W-1:0]  i_key,
    input  logic [CNT_W-1:0]         i_count,
    input  logic signed [KEY_W-1:0]  i_rd_a,
    input  logic signed [KEY_W-1:0]  i_rd_b,
    output t_sift_dec                o_dec
);

    logic [HEAP_AW+1:0]       left_idx;
    logic [HEAP_AW+1:0]       right_idx;
    logic                     left_ok;
    logic                     right_ok;
    logic                     take_left;
    logic                     take_right;
    logic signed [KEY_W-1:0]  left_best;

    // Sift up: rd_a holds the parent; stop at the root or when parent <= key
    assign o_dec.up_stop   = (i_pos == '0) || (i_rd_a <= i_key);
    assign o_dec.up_parent = f_parent(i_pos);

    // Sift down: rd_a left child, rd_b right child, bounded by the count
    assign left_idx   = f_left(i_pos);
    assign right_idx  = f_right(i_pos);
    assign left_ok    = left_idx < {1'b0, i_count};
    assign right_ok   = right_idx < {1'b0, i_count};
    assign take_left  = left_ok && (i_rd_a < i_key);
    assign left_best  = take_left ? i_rd_a : i_key;
    assign take_right = right_ok && (i_rd_b < left_best);

    assign o_dec.down_stop = !(take_left || take_right);
    assign o_dec.down_best = take_right ? right_idx[HEAP_AW-1:0] : left_idx[HEAP_AW-1:0];
    assign o_dec.down_key  = take_right ? i_rd_b : i_rd_a;

endmodule

// ===== hw/rtl/binary_min_heap_queue_core.sv =====
// Binary min-heap priority queue of signed 32-bit keys, top level.
// Depends on bmhq_pkg, bmhq_ram, bmhq_sift_step and the assertion macro header.
//
// Usage:
//   A request (insert, extract minimum, decrease key, delete at index) is taken
//   on a rising edge with start high and busy low. Exactly one result follows on
//   o_rsp, marked by o_done for one cycle; the receiver must take it then.
//   Rejected requests (full, empty, bad index) never raise busy: the result
//   comes in the next cycle. Otherwise busy stays high through the states
//     insert / decrease key : S_UP, one per level (up to 6 sift-up swaps)
//     extract minimum       : S_TAKE, S_RD_LAST, then S_DOWN (up to 5 swaps)
//     delete at index       : S_RD_DEL, then as decrease key, then as extract
//   An extract or delete that empties the heap skips the refill.
//   o_done rises in the cycle busy falls; a new request may be taken in
//   that same cycle. The cost per level is one pass through the heap RAM
//   (registered read, compare, write back), one tree level per cycle.
//   Results hold min_key and entry_count as they stand after the request.
//   Reset (synchronous, active low) empties the heap at once; the RAM itself
//   is not cleared, only entries below the count are ever used.
`include "binary_min_heap_queue_core_assert.svh"

module binary_min_heap_queue_core
    import bmhq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RD_DEL  = 6'b000010,
        S_UP      = 6'b000100,
        S_TAKE    = 6'b001000,
        S_RD_LAST = 6'b010000,
        S_DOWN    = 6'b100000
    } t_state;

    // Control registers
    t_state                   r_state,  n_state;
    logic [CNT_W-1:0]         r_count,  n_count;
    logic                     r_done,   n_done;
    // Datapath registers
    logic [HEAP_AW-1:0]       r_pos,    n_pos;
    logic signed [KEY_W-1:0]  r_key,    n_key;
    logic signed [KEY_W-1:0]  r_root,   n_root;
    logic                     r_is_del, n_is_del;
    logic signed [KEY_W-1:0]  r_popped, n_popped;
    t_status                  r_status, n_status;

    // RAM ports
    logic                     ram_we;
    logic [HEAP_AW-1:0]       ram_waddr;
    logic signed [KEY_W-1:0]  ram_wdata;
    logic [HEAP_AW-1:0]       ram_raddr_a;
    logic [HEAP_AW-1:0]       ram_raddr_b;
    logic signed [KEY_W-1:0]  rd_a;
    logic signed [KEY_W-1:0]  rd_b;

    logic [CNT_W-1:0]         cnt_dec;
    logic [HEAP_AW+1:0]       best_left;
    logic [HEAP_AW+1:0]       best_right;
    t_sift_dec                dec;

    bmhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    bmhq_sift_step u_sift_step (
        .i_pos   (r_pos),
        .i_key   (r_key),
        .i_count (r_count),
        .i_rd_a  (rd_a),
        .i_rd_b  (rd_b),
        .o_dec   (dec)
    );

    assign cnt_dec    = CNT_W'(r_count - 1'b1);
    assign best_left  = f_left(dec.down_best);
    assign best_right = f_right(dec.down_best);

    // Sequencer: request decode, sift walks and root removal
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_done      = 1'b0;
        n_pos       = r_pos;
        n_key       = r_key;
        n_is_del    = r_is_del;
        n_popped    = r_popped;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_key;
        ram_raddr_a = f_parent(r_pos);
        ram_raddr_b = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_popped = '0;
                    n_status = ST_OK;
                    n_is_del = 1'b0;
                    case (i_req.func)
                        FN_INSERT: begin
                            if (r_count == CNT_W'(HEAP_DEPTH)) begin
                                n_status = ST_OVERFLOW;
                                n_done   = 1'b1;
                            end else begin
                                n_count     = CNT_W'(r_count + 1'b1);
                                n_pos       = r_count[HEAP_AW-1:0];
                                n_key       = i_req.key_value;
                                ram_raddr_a = f_parent(r_count[HEAP_AW-1:0]);
                                n_state     = S_UP;
                            end
                        end
                        FN_EXTRACT: begin
                            if (r_count == '0) begin
                                n_popped = KEY_MAX;
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                n_popped = r_root;
                                n_state  = S_TAKE;
                            end
                        end
                        FN_DECREASE, FN_DELETE: begin
                            if ({1'b0, i_req.entry_index} >= r_count) begin
                                n_status = ST_BAD_INDEX;
                                n_done   = 1'b1;
                            end else if (i_req.func == FN_DECREASE) begin
                                n_pos       = i_req.entry_index;
                                n_key       = i_req.key_value;
                                ram_raddr_a = f_parent(i_req.entry_index);
                                n_state     = S_UP;
                            end else begin
                                n_pos       = i_req.entry_index;
                                n_is_del    = 1'b1;
                                ram_raddr_a = i_req.entry_index;
                                n_state     = S_RD_DEL;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Old key at the index is the delete result; lower it to the minimum
            S_RD_DEL: begin
                n_popped    = rd_a;
                n_key       = KEY_MIN;
                ram_raddr_a = f_parent(r_pos);
                n_state     = S_UP;
            end

            // One sift-up level: parent arrived in rd_a
            S_UP: begin
                ram_we = 1'b1;
                if (dec.up_stop) begin
                    ram_wdata = r_key;
                    if (r_is_del) begin
                        n_state = S_TAKE;
                    end else begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                end else begin
                    ram_wdata   = rd_a;
                    n_pos       = dec.up_parent;
                    ram_raddr_a = f_parent(dec.up_parent);
                end
            end

            // Remove the root; fetch the last entry to refill it
            S_TAKE: begin
                n_count     = cnt_dec;
                ram_raddr_a = cnt_dec[HEAP_AW-1:0];
                if (cnt_dec == '0) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = S_RD_LAST;
                end
            end

            // Last entry arrived: sift it down from the root
            S_RD_LAST: begin
                n_key       = rd_a;
                n_pos       = '0;
                ram_raddr_a = HEAP_AW'(1);
                ram_raddr_b = HEAP_AW'(2);
                n_state     = S_DOWN;
            end

            // One sift-down level: children arrived in rd_a and rd_b
            S_DOWN: begin
                ram_we = 1'b1;
                if (dec.down_stop) begin
                    ram_wdata = r_key;
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                end else begin
                    ram_wdata   = dec.down_key;
                    n_pos       = dec.down_best;
                    ram_raddr_a = best_left[HEAP_AW-1:0];
                    ram_raddr_b = best_right[HEAP_AW-1:0];
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Root shadow, kept in step with every write to position zero
    always_comb begin
        n_root = r_root;
        if (ram_we && (ram_waddr == '0)) begin
            n_root = ram_wdata;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_root   <= n_root;
        r_is_del <= n_is_del;
        r_popped <= n_popped;
        r_status <= n_status;
    end

    // Outputs
    assign busy                = (r_state != S_IDLE);
    assign o_done              = r_done;
    assign o_rsp.popped_key    = r_popped;
    assign o_rsp.status        = r_status;
    assign o_rsp.min_key       = (r_count != '0) ? r_root : '0;
    assign o_rsp.entry_count   = r_count;

    // Checks
    `BMHQ_ASSERT_SAME(a_done_when_idle, o_done, !busy, "result strobe while busy")
    `BMHQ_ASSERT_HOLDS(a_count_bound, r_count <= CNT_W'(HEAP_DEPTH), "count beyond depth")
    `BMHQ_ASSERT_NEXT(a_request_progress, start && !busy, busy || o_done,
                      "accepted request neither working nor answered")
    `BMHQ_ASSERT_SAME(a_overflow_full, o_done && (o_rsp.status == ST_OVERFLOW),
                      r_count == CNT_W'(HEAP_DEPTH), "overflow reported on a heap not full")

endmodule

// ===== bench/tb_binary_min_heap_queue_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for binary_min_heap_queue_core: a directed table, then random traffic.
// Depends on bmhq_pkg; results are checked against pinned table rows or an in-bench heap predictor.
module tb_binary_min_heap_queue_core;
    import bmhq_pkg::*;

    localparam int RAND_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 24;   // longer than the slowest delete

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_traffic_mode;

    typedef struct {
        t_req req;
        bit   pinned;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    // Predictor state: heap array and count
    logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
    int heap_count;

    t_rsp expected_rsps[$];
    t_stim_row stim_rows[$];
    bit pin_valid;
    t_rsp pin_rsp;
    int errors;
    int idle_pct;

    binary_min_heap_queue_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Sift up with strict comparison against the parent
    function automatic void sift_up(int pos);
        int up;
        logic signed [KEY_W-1:0] t;
        while (pos != 0) begin
            up = (pos - 1) / 2;
            if (heap_keys[up] <= heap_keys[pos]) break;
            t = heap_keys[up];
            heap_keys[up] = heap_keys[pos];
            heap_keys[pos] = t;
            pos = up;
        end
    endfunction

    // Sift down, swapping with the smallest of parent and both children
    function automatic void sift_down(int pos);
        int lc;
        int rc;
        int best;
        logic signed [KEY_W-1:0] t;
        forever begin
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            best = pos;
            if (lc < heap_count && heap_keys[lc] < heap_keys[best]) best = lc;
            if (rc < heap_count && heap_keys[rc] < heap_keys[best]) best = rc;
            if (best == pos) break;
            t = heap_keys[best];
            heap_keys[best] = heap_keys[pos];
            heap_keys[pos] = t;
            pos = best;
        end
    endfunction

    function automatic logic signed [KEY_W-1:0] take_root();
        logic signed [KEY_W-1:0] root;
        root = heap_keys[0];
        heap_count--;
        if (heap_count > 0) begin
            heap_keys[0] = heap_keys[heap_count];
            sift_down(0);
        end
        return root;
    endfunction

    // Apply one request to the predicted heap and return its result
    function automatic t_rsp predict_rsp(t_req r);
        t_rsp o;
        int idx;
        o.popped_key = '0;
        o.status = ST_OK;
        idx = int'(r.entry_index);
        case (r.func)
            FN_INSERT: begin
                if (heap_count >= HEAP_DEPTH) begin
                    o.status = ST_OVERFLOW;
                end else begin
                    heap_keys[heap_count] = r.key_value;
                    heap_count++;
                    sift_up(heap_count - 1);
                end
            end
            FN_EXTRACT: begin
                if (heap_count == 0) begin
                    o.popped_key = KEY_MAX;
                    o.status = ST_EMPTY;
                end else begin
                    o.popped_key = take_root();
                end
            end
            default: begin
                if (idx >= heap_count) begin
                    o.status = ST_BAD_INDEX;
                end else if (r.func == FN_DECREASE) begin
                    heap_keys[idx] = r.key_value;
                    sift_up(idx);
                end else begin
                    // delete: force to the top, then extract it
                    o.popped_key = heap_keys[idx];
                    heap_keys[idx] = KEY_MIN;
                    sift_up(idx);
                    void'(take_root());
                end
            end
        endcase
        o.min_key = (heap_count > 0) ? heap_keys[0] : '0;
        o.entry_count = CNT_W'(heap_count);
        return o;
    endfunction

    // Key mix: extremes, a narrow band for duplicates, full range
    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return '0;
            3: return '1;
            4, 5, 6: return KEY_W'(int'($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req next_req(t_traffic_mode m);
        t_req r;
        int pick;
        r.key_value = rand_key();
        if (heap_count > 0 && $urandom_range(0, 99) < 85)
            r.entry_index = HEAP_AW'($urandom_range(0, heap_count - 1));
        else
            r.entry_index = HEAP_AW'($urandom_range(0, HEAP_DEPTH - 1));
        pick = $urandom_range(0, 99);
        case (m)
            MODE_FILL:
                r.func = (pick < 88) ? FN_INSERT : (pick < 93) ? FN_EXTRACT :
                         (pick < 97) ? FN_DECREASE : FN_DELETE;
            MODE_DRAIN:
                r.func = (pick < 10) ? FN_INSERT : (pick < 65) ? FN_EXTRACT :
                         (pick < 80) ? FN_DECREASE : FN_DELETE;
            default:
                r.func = (pick < 25) ? FN_INSERT : (pick < 50) ? FN_EXTRACT :
                         (pick < 75) ? FN_DECREASE : FN_DELETE;
        endcase
        // decrease key mostly lowers the stored value
        if (r.func == FN_DECREASE && r.entry_index < heap_count && $urandom_range(0, 2) != 0)
            r.key_value = heap_keys[r.entry_index] - KEY_W'($urandom_range(0, 100));
        return r;
    endfunction

    function automatic void add_row(t_func f, logic signed [KEY_W-1:0] key, int idx,
                                    bit pinned = 1'b0,
                                    logic signed [KEY_W-1:0] popped = '0,
                                    t_status st = ST_OK,
                                    logic signed [KEY_W-1:0] mn = '0,
                                    int cnt = 0);
        t_stim_row row;
        row.req.func = f;
        row.req.key_value = key;
        row.req.entry_index = HEAP_AW'(idx);
        row.pinned = pinned;
        row.rsp.popped_key = popped;
        row.rsp.status = st;
        row.rsp.min_key = mn;
        row.rsp.entry_count = CNT_W'(cnt);
        stim_rows.push_back(row);
    endfunction

    // Drive one request at the falling edge and hold it until taken
    task automatic issue_request(t_req r, bit pinned, t_rsp rsp);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        pin_valid = pinned;
        pin_rsp = rsp;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        pin_valid = 1'b0;
    endtask

    // Result check and prediction at each rising edge
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_rsps.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: popped=%0d st=%0d min=%0d cnt=%0d",
                             $time, o_rsp.popped_key, o_rsp.status, o_rsp.min_key,
                             o_rsp.entry_count);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_rsp.popped_key !== exp_rsp.popped_key ||
                        o_rsp.status !== exp_rsp.status ||
                        o_rsp.min_key !== exp_rsp.min_key ||
                        o_rsp.entry_count !== exp_rsp.entry_count) begin
                        errors++;
                        $display("%0t: mismatch exp popped=%0d st=%0d min=%0d cnt=%0d %s",
                                 $time, exp_rsp.popped_key, exp_rsp.status,
                                 exp_rsp.min_key, exp_rsp.entry_count, "");
                        $display("%0t:          got popped=%0d st=%0d min=%0d cnt=%0d",
                                 $time, o_rsp.popped_key, o_rsp.status, o_rsp.min_key,
                                 o_rsp.entry_count);
                    end
                end
            end
            if (start && !busy) begin
                exp_rsp = predict_rsp(i_req);
                if (pin_valid) exp_rsp = pin_rsp;
                expected_rsps.push_back(exp_rsp);
            end
        end
    end

    initial begin
        t_traffic_mode mode;
        t_req r;
        t_rsp no_rsp;
        int sent;
        int seg;
        int overflows;
        int guard;
        int waited;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        pin_valid = 1'b0;
        pin_rsp = '0;
        no_rsp = '0;
        errors = 0;
        idle_pct = 0;
        heap_count = 0;
        for (int i = 0; i < HEAP_DEPTH; i++) heap_keys[i] = '0;

        // Directed: empty heap, extremes, bad indexes, increase via decrease key, deletes
        add_row(FN_EXTRACT, 0, 0, 1, KEY_MAX, ST_EMPTY, 0, 0);
        add_row(FN_DECREASE, 5, 0, 1, 0, ST_BAD_INDEX, 0, 0);
        add_row(FN_DELETE, 0, 63, 1, 0, ST_BAD_INDEX, 0, 0);
        add_row(FN_INSERT, KEY_MAX, 0, 1, 0, ST_OK, KEY_MAX, 1);
        add_row(FN_INSERT, KEY_MIN, 0, 1, 0, ST_OK, KEY_MIN, 2);
        add_row(FN_INSERT, 0, 0, 1, 0, ST_OK, KEY_MIN, 3);
        add_row(FN_INSERT, -1, 0, 1, 0, ST_OK, KEY_MIN, 4);
        add_row(FN_DECREASE, 3, 4, 1, 0, ST_BAD_INDEX, KEY_MIN, 4);
        add_row(FN_DELETE, 3, 63, 1, 0, ST_BAD_INDEX, KEY_MIN, 4);
        add_row(FN_DECREASE, -5, 3);
        add_row(FN_DECREASE, 100, 0);       // raises the root, order left broken
        add_row(FN_INSERT, 7, 0);
        add_row(FN_INSERT, 7, 0);
        add_row(FN_INSERT, 7, 0);
        add_row(FN_DELETE, 0, 2);
        add_row(FN_DELETE, 0, 0);
        for (int i = 0; i < 5; i++) add_row(FN_EXTRACT, 0, 0);
        add_row(FN_EXTRACT, 0, 0, 1, KEY_MAX, ST_EMPTY, 0, 0);
        add_row(FN_INSERT, 42, 0, 1, 0, ST_OK, 42, 1);
        add_row(FN_DELETE, 0, 0, 1, 42, ST_OK, 0, 0);
        add_row(FN_DECREASE, 1, 0, 1, 0, ST_BAD_INDEX, 0, 0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[i]) issue_request(stim_rows[i].req, stim_rows[i].pinned,
                                             stim_rows[i].rsp);

        // Random traffic in segments: fill to overflow, drain to empty, or mixed
        sent = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 3))
                0: mode = MODE_FILL;
                1: mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 78;
                default: idle_pct = 34;
            endcase
            seg = $urandom_range(30, 100);
            overflows = 0;
            guard = 0;
            forever begin
                if (sent >= RAND_ITEMS) break;
                if (mode == MODE_FILL && overflows >= 2) break;
                if (mode == MODE_DRAIN && heap_count == 0 && guard > 0) break;
                if (mode == MODE_MIXED && guard >= seg) break;
                if (guard >= 400) break;
                r = next_req(mode);
                if (mode == MODE_DRAIN && heap_count == 0) r.func = FN_EXTRACT;
                if (r.func == FN_INSERT && heap_count == HEAP_DEPTH) overflows++;
                issue_request(r, 1'b0, no_rsp);
                guard++;
                sent++;
            end
        end

        start <= 1'b0;
        waited = 0;
        while (expected_rsps.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_rsps.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_rsps.size());
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
